// ===== hw/rtl/mf3_pkg.sv =====
package mf3_pkg;

    localparam int PIX_W   = 24;
    localparam int CH_W    = 8;
    localparam int ROW_W   = 17;
    localparam int Q_DEPTH = 4;

    // register indexes
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    typedef logic [CH_W-1:0]  t_ch;
    typedef logic [PIX_W-1:0] t_pix;

    // one window column plus what the back end has to emit around it
    typedef struct packed {
        t_pix top;
        t_pix mid;
        t_pix bot;
        logic pre_emit;   // emit last column of a row before the shift
        logic pre_w1;     // single-column frame: left column is the center one
        logic post_emit;  // emit after the shift
        logic post_x1;    // first column of a row: left column replicates center
        logic row_end;
        logic frame_end;
    } t_col;

    typedef struct packed {
        logic        we;
        logic        idx;
        logic [31:0] data;
    } t_cfg_wr;

    typedef struct packed {
        t_ch lo;
        t_ch md;
        t_ch hi;
    } t_tri;

    function automatic t_ch min2(input t_ch a, input t_ch b);
        return (a < b) ? a : b;
    endfunction

    function automatic t_ch max2(input t_ch a, input t_ch b);
        return (a > b) ? a : b;
    endfunction

    function automatic t_ch med3(input t_ch a, input t_ch b, input t_ch c);
        return max2(min2(a, b), min2(max2(a, b), c));
    endfunction

    function automatic t_tri sort3(input t_ch a, input t_ch b, input t_ch c);
        t_tri t;
        t.lo = min2(min2(a, b), c);
        t.hi = max2(max2(a, b), c);
        t.md = med3(a, b, c);
        return t;
    endfunction

endpackage

// ===== hw/rtl/mf3_queue.sv =====
module mf3_queue
    import mf3_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_col     i_data,
    input  logic     i_pop,
    output t_col     o_data,
    output logic     o_valid,
    output logic [$clog2(Q_DEPTH+1)-1:0] o_count
);
    localparam int AW = $clog2(Q_DEPTH);
    localparam int CW = $clog2(Q_DEPTH+1);

    t_col          r_mem [Q_DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [CW-1:0] r_cnt;
    logic          do_pop;

    assign do_pop  = i_pop && (r_cnt != '0);
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];
    assign o_count = r_cnt;

    // store word
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    // advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == AW'(Q_DEPTH-1)) ? '0 : r_wp + AW'(1);
            end
            if (do_pop) begin
                r_rp <= (r_rp == AW'(Q_DEPTH-1)) ? '0 : r_rp + AW'(1);
            end
            r_cnt <= r_cnt + CW'(i_push) - CW'(do_pop);
        end
    end
endmodule

// ===== hw/rtl/mf3_front.sv =====
module mf3_front
    import mf3_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg_wr     i_cfg,
    output logic [10:0] o_width,
    output logic [15:0] o_height,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_action,
    input  t_pix        i_pix,
    input  logic [$clog2(Q_DEPTH+1)-1:0] i_q_count,
    output logic        o_push,
    output t_col        o_col
);
    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH+1);
    localparam int PW = $clog2(MAX_WIDTH+2);
    localparam int QW = $clog2(Q_DEPTH+1);

    logic [10:0]    r_width;
    logic [15:0]    r_height;
    logic [CW-1:0]  r_col;
    logic [ROW_W-1:0] r_row;
    logic [PW-1:0]  r_pend;

    t_pix r_upper [MAX_WIDTH];
    t_pix r_middle [MAX_WIDTH];
    t_pix r_up_rd, r_mid_rd;

    // second stage: read data arrives
    logic           r_s2_valid;
    logic [CW-1:0]  r_s2_x;
    logic           r_s2_wr;
    logic           r_s2_top_mid, r_s2_bot_mid;
    t_pix           r_s2_pix;
    logic           r_s2_pre, r_s2_pre_w1, r_s2_post, r_s2_post_x1, r_s2_rend, r_s2_fend;
    logic           r_fwd;
    t_pix           r_fwd_pix;

    logic [WW-1:0]    w_eff;
    logic [15:0]      h_eff;
    logic [ROW_W-1:0] h_ext;
    logic             accept, ignore, restart, act_px, emit_pre, emit_post;
    logic [CW-1:0]    x;
    logic [ROW_W-1:0] rwu;
    logic [PW-1:0]    pend_inc;
    logic [WW-1:0]    x_plus;
    t_pix             top_raw;

    assign o_width  = r_width;
    assign o_height = r_height;

    // clamp frame size
    always_comb begin
        if (r_width == '0) begin
            w_eff = WW'(1);
        end else if (32'(r_width) > MAX_WIDTH) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(r_width);
        end
        h_eff = (r_height == '0) ? 16'd1 : r_height;
        h_ext = ROW_W'(h_eff);
    end

    assign o_ready = (QW'(32'(i_q_count) + 32'(r_s2_valid)) < QW'(Q_DEPTH));
    assign accept  = i_valid && o_ready;
    assign act_px  = !i_action;

    // classify the word
    always_comb begin
        if (act_px) begin
            ignore  = (r_row >= h_ext) && (r_pend != '0);
            restart = (r_row >= h_ext);
        end else begin
            ignore  = (r_row < h_ext) || (r_pend == '0);
            restart = 1'b0;
        end
        x         = (restart || (WW'(r_col) >= w_eff)) ? '0 : r_col;
        rwu       = restart ? '0 : r_row;
        emit_pre  = (x == '0) && (rwu >= ROW_W'(2)) && (rwu <= h_ext + ROW_W'(1));
        emit_post = (x != '0) && (rwu >= ROW_W'(1)) && (rwu <= h_ext);
        pend_inc  = r_pend + PW'(act_px);
        x_plus    = WW'(x) + WW'(1);
    end

    // line stores: registered read, old data on a same-address write
    always_ff @(posedge i_clk) begin
        if (accept && !ignore && act_px) begin
            r_middle[x] <= i_pix;
        end
        r_mid_rd <= r_middle[x];
    end

    always_ff @(posedge i_clk) begin
        if (r_s2_valid && r_s2_wr) begin
            r_upper[r_s2_x] <= r_mid_rd;
        end
        r_up_rd <= r_upper[x];
    end

    // second stage payload
    always_ff @(posedge i_clk) begin
        r_s2_x       <= x;
        r_s2_wr      <= act_px;
        r_s2_pix     <= i_pix;
        r_s2_top_mid <= (rwu <= ROW_W'(1));
        r_s2_bot_mid <= i_action || (rwu >= h_ext);
        r_s2_pre     <= emit_pre;
        r_s2_pre_w1  <= (w_eff == WW'(1));
        r_s2_post    <= emit_post;
        r_s2_post_x1 <= (x == CW'(1));
        r_s2_rend    <= 1'b1;
        r_s2_fend    <= (rwu == h_ext + ROW_W'(1));
        // bypass an upper-store write that lands as this word reads
        r_fwd        <= r_s2_valid && r_s2_wr && (r_s2_x == x);
        r_fwd_pix    <= r_mid_rd;
    end

    // control: counters, config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width    <= 11'd640;
            r_height   <= 16'd480;
            r_col      <= '0;
            r_row      <= '0;
            r_pend     <= '0;
            r_s2_valid <= 1'b0;
        end else begin
            r_s2_valid <= accept && !ignore;
            if (i_cfg.we) begin
                if (i_cfg.idx == REG_WIDTH) begin
                    r_width <= i_cfg.data[10:0];
                end else begin
                    r_height <= i_cfg.data[15:0];
                end
                r_col  <= '0;
                r_row  <= '0;
                r_pend <= '0;
            end else if (accept && !ignore) begin
                if ((emit_pre || emit_post) && (pend_inc != '0)) begin
                    r_pend <= pend_inc - PW'(1);
                end else begin
                    r_pend <= pend_inc;
                end
                if (x_plus >= w_eff) begin
                    r_col <= '0;
                    r_row <= rwu + ROW_W'(1);
                end else begin
                    r_col <= CW'(x_plus);
                    r_row <= rwu;
                end
            end
        end
    end

    // form the column word
    always_comb begin
        top_raw         = r_fwd ? r_fwd_pix : r_up_rd;
        o_push          = r_s2_valid;
        o_col.mid       = r_mid_rd;
        o_col.top       = r_s2_top_mid ? r_mid_rd : top_raw;
        o_col.bot       = r_s2_bot_mid ? r_mid_rd : r_s2_pix;
        o_col.pre_emit  = r_s2_pre;
        o_col.pre_w1    = r_s2_pre_w1;
        o_col.post_emit = r_s2_post;
        o_col.post_x1   = r_s2_post_x1;
        o_col.row_end   = r_s2_pre && r_s2_rend;
        o_col.frame_end = r_s2_pre && r_s2_fend;
    end
endmodule

// ===== hw/rtl/mf3_back.sv =====
module mf3_back
    import mf3_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_q_valid,
    input  t_col i_col,
    output logic o_pop,
    output logic o_valid,
    input  logic i_ready,
    output t_ch  o_red,
    output t_ch  o_green,
    output t_ch  o_blue,
    output logic o_row_end,
    output logic o_frame_end
);
    t_pix r_win [9];
    t_pix n_win [9];
    t_pix sel [9];
    logic adv, take, emit;

    logic r_a_valid, r_a_rend, r_a_fend;
    t_pix r_a_pix [9];
    logic r_b_valid, r_b_rend, r_b_fend;
    t_tri r_b_tri [3][3];
    logic r_c_valid, r_c_rend, r_c_fend;
    t_tri r_c_tri [3];
    logic r_o_valid, r_o_rend, r_o_fend;
    t_ch  r_o_ch [3];

    assign adv   = !r_o_valid || i_ready;
    assign take  = adv && i_q_valid;
    assign o_pop = take;
    assign emit  = i_col.pre_emit || i_col.post_emit;

    // shift window and pick the nine taps
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            n_win[r*3]   = r_win[r*3+1];
            n_win[r*3+1] = r_win[r*3+2];
        end
        n_win[2] = i_col.top;
        n_win[5] = i_col.mid;
        n_win[8] = i_col.bot;
        for (int r = 0; r < 3; r++) begin
            if (i_col.pre_emit) begin
                sel[r*3]   = i_col.pre_w1 ? r_win[r*3+2] : r_win[r*3+1];
                sel[r*3+1] = r_win[r*3+2];
                sel[r*3+2] = r_win[r*3+2];
            end else begin
                sel[r*3]   = i_col.post_x1 ? n_win[r*3+1] : n_win[r*3];
                sel[r*3+1] = n_win[r*3+1];
                sel[r*3+2] = n_win[r*3+2];
            end
        end
    end

    // window register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 9; i++) begin
                r_win[i] <= '0;
            end
        end else if (take) begin
            for (int i = 0; i < 9; i++) begin
                r_win[i] <= n_win[i];
            end
        end
    end

    // median stages: taps, row sorts, column reduce, final median
    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int i = 0; i < 9; i++) begin
                r_a_pix[i] <= sel[i];
            end
            r_a_rend <= i_col.row_end;
            r_a_fend <= i_col.frame_end;
            for (int c = 0; c < 3; c++) begin
                for (int r = 0; r < 3; r++) begin
                    r_b_tri[c][r] <= sort3(r_a_pix[r*3][c*CH_W +: CH_W],
                                           r_a_pix[r*3+1][c*CH_W +: CH_W],
                                           r_a_pix[r*3+2][c*CH_W +: CH_W]);
                end
                r_c_tri[c].lo <= max2(max2(r_b_tri[c][0].lo, r_b_tri[c][1].lo),
                                      r_b_tri[c][2].lo);
                r_c_tri[c].md <= med3(r_b_tri[c][0].md, r_b_tri[c][1].md,
                                      r_b_tri[c][2].md);
                r_c_tri[c].hi <= min2(min2(r_b_tri[c][0].hi, r_b_tri[c][1].hi),
                                      r_b_tri[c][2].hi);
                r_o_ch[c] <= med3(r_c_tri[c].lo, r_c_tri[c].md, r_c_tri[c].hi);
            end
            r_b_rend <= r_a_rend;
            r_b_fend <= r_a_fend;
            r_c_rend <= r_b_rend;
            r_c_fend <= r_b_fend;
            r_o_rend <= r_c_rend;
            r_o_fend <= r_c_fend;
        end
    end

    // stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else if (adv) begin
            r_a_valid <= take && emit;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
            r_o_valid <= r_c_valid;
        end
    end

    assign o_valid     = r_o_valid;
    assign o_red       = r_o_ch[2];
    assign o_green     = r_o_ch[1];
    assign o_blue      = r_o_ch[0];
    assign o_row_end   = r_o_rend;
    assign o_frame_end = r_o_fend;
endmodule

// ===== hw/rtl/median3x3_rgb_filter.sv =====
// 3x3 median filter on a raster stream of 24-bit RGB pixels, each channel
// filtered on its own, borders by edge replication. The block takes one word
// per clock unless o_ready is low for a full column queue: each line store is
// a RAM with one write and one read port, accessed once per word, and the
// median is a four-stage sorting pipeline. The word that completes a result,
// image_width+1 words after its own pixel, passes the front second stage, the
// column queue and the median stages to o_valid. After the last row, send
// flush words (i_action high) to drain it; they produce nothing once done.
// Register 0 (address 0) is the width, register 1 (address 4) the height;
// a write restarts the frame and must happen while the block is idle.
module median3x3_rgb_filter
    import mf3_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_action,
    input  logic [7:0]  i_in_red,
    input  logic [7:0]  i_in_green,
    input  logic [7:0]  i_in_blue,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_out_red,
    output logic [7:0]  o_out_green,
    output logic [7:0]  o_out_blue,
    output logic        o_row_end,
    output logic        o_frame_end
);
    t_cfg_wr     cfg;
    logic [10:0] width;
    logic [15:0] height;
    logic        push, pop, q_valid;
    t_col        push_col, q_col;
    logic [$clog2(Q_DEPTH+1)-1:0] q_count;

    // decode register access
    assign pready   = 1'b1;
    assign cfg.we   = psel && penable && pwrite;
    assign cfg.idx  = paddr[2];
    assign cfg.data = pwdata;
    assign prdata   = (paddr[2] == REG_WIDTH) ? 32'(width) : 32'(height);

    mf3_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .o_width   (width),
        .o_height  (height),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_action  (i_action),
        .i_pix     ({i_in_red, i_in_green, i_in_blue}),
        .i_q_count (q_count),
        .o_push    (push),
        .o_col     (push_col)
    );

    mf3_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_col),
        .i_pop   (pop),
        .o_data  (q_col),
        .o_valid (q_valid),
        .o_count (q_count)
    );

    mf3_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_col       (q_col),
        .o_pop       (pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_red       (o_out_red),
        .o_green     (o_out_green),
        .o_blue      (o_out_blue),
        .o_row_end   (o_row_end),
        .o_frame_end (o_frame_end)
    );
endmodule

// ===== tb/tb_median3x3_rgb_filter.sv =====
module tb_median3x3_rgb_filter;
    import mf3_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAXW       = 1024;
    localparam int SETTLE_CYC = 16;

    typedef struct packed {
        t_ch red;
        t_ch green;
        t_ch blue;
        bit  row_end;
        bit  frame_end;
    } t_median;

    // predicts the filtered stream and checks the block against it
    class median_scoreboard;
        bit [10:0] width_reg;
        bit [15:0] height_reg;
        t_pix      upper_row [MAXW];
        t_pix      middle_row[MAXW];
        t_pix      win[9];
        int unsigned col;
        int unsigned row;
        int unsigned pending;
        t_median   medians_due[$];
        int        errors;

        function void reset_state();
            width_reg  = 11'd640;
            height_reg = 16'd480;
            foreach (upper_row[i]) upper_row[i] = '0;
            foreach (middle_row[i]) middle_row[i] = '0;
            foreach (win[i]) win[i] = '0;
            col = 0;
            row = 0;
            pending = 0;
            medians_due.delete();
            errors = 0;
        endfunction

        function void set_register(logic idx, bit [31:0] value);
            if (idx == REG_WIDTH) width_reg = value[10:0];
            else height_reg = value[15:0];
            col = 0;
            row = 0;
            pending = 0;
        endfunction

        function t_ch channel_median(t_pix v[9], int shift);
            int s[9];
            int t;
            int j;
            foreach (s[i]) s[i] = (v[i] >> shift) & 8'hFF;
            for (int i = 1; i < 9; i++) begin
                t = s[i];
                j = i - 1;
                while (j >= 0 && s[j] > t) begin
                    s[j+1] = s[j];
                    j--;
                end
                s[j+1] = t;
            end
            return t_ch'(s[4]);
        endfunction

        function void push_median(int lc, int cc, int rc, bit rend, bit fend);
            t_pix    v[9];
            t_median m;
            for (int r = 0; r < 3; r++) begin
                v[r*3]   = win[r*3+lc];
                v[r*3+1] = win[r*3+cc];
                v[r*3+2] = win[r*3+rc];
            end
            m.red       = channel_median(v, 16);
            m.green     = channel_median(v, 8);
            m.blue      = channel_median(v, 0);
            m.row_end   = rend;
            m.frame_end = fend;
            medians_due.push_back(m);
        endfunction

        // advance the frame by one accepted word
        function void note_word(bit flush, t_pix pix);
            int unsigned w;
            int unsigned h;
            int unsigned x;
            int unsigned rw;
            t_pix        top;
            t_pix        mid;
            t_pix        bot;
            bit          made;
            w = (width_reg == 0) ? 1 : (width_reg > MAXW) ? MAXW : width_reg;
            h = (height_reg == 0) ? 1 : height_reg;
            made = 0;
            if (!flush) begin
                if (row >= h) begin
                    if (pending != 0) return;
                    col = 0;
                    row = 0;
                end
            end else if (row < h || pending == 0) begin
                return;
            end
            x = (col >= w) ? 0 : col;
            rw = row;
            // last column of the row two back, before the window shifts
            if (x == 0 && rw >= 2 && rw - 2 <= h - 1) begin
                push_median((w == 1) ? 2 : 1, 2, 2, 1, rw - 2 == h - 1);
                made = 1;
            end
            top = upper_row[x];
            mid = middle_row[x];
            bot = (flush || rw >= h) ? mid : pix;
            if (rw <= 1) top = mid;
            if (!flush) begin
                upper_row[x]  = mid;
                middle_row[x] = pix;
                pending++;
            end
            for (int r = 0; r < 3; r++) begin
                win[r*3]   = win[r*3+1];
                win[r*3+1] = win[r*3+2];
            end
            win[2] = top;
            win[5] = mid;
            win[8] = bot;
            if (x > 0 && rw >= 1 && rw <= h) begin
                push_median((x == 1) ? 1 : 0, 1, 2, 0, 0);
                made = 1;
            end
            if (made && pending != 0) pending--;
            x++;
            if (x >= w) begin
                x = 0;
                row = rw + 1;
            end
            col = x;
        endfunction

        function void check_median(t_median got);
            t_median exp_m;
            if (medians_due.size() == 0) begin
                $display("%0t: unexpected result r=%0d g=%0d b=%0d", $time,
                         got.red, got.green, got.blue);
                errors++;
                return;
            end
            exp_m = medians_due.pop_front();
            if (got != exp_m) begin
                $display("%0t: mismatch expected r=%0d g=%0d b=%0d re=%0b fe=%0b",
                         $time, exp_m.red, exp_m.green, exp_m.blue,
                         exp_m.row_end, exp_m.frame_end);
                $display("%0t:          actual   r=%0d g=%0d b=%0d re=%0b fe=%0b",
                         $time, got.red, got.green, got.blue,
                         got.row_end, got.frame_end);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        i_valid;
    logic        o_ready;
    logic        i_action;
    logic [7:0]  i_in_red;
    logic [7:0]  i_in_green;
    logic [7:0]  i_in_blue;
    logic        o_valid;
    logic        i_ready;
    logic [7:0]  o_out_red;
    logic [7:0]  o_out_green;
    logic [7:0]  o_out_blue;
    logic        o_row_end;
    logic        o_frame_end;

    median_scoreboard sb;
    int send_idle_pct;
    int recv_stall_pct;
    int hold_cycles;
    int words_sent;

    median3x3_rgb_filter u_top (.*);

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // receiver: random stalls, or a long hold-off when asked
    always @(posedge i_clk) begin
        if (hold_cycles > 0) begin
            i_ready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // watch both channels at the edge
    always @(posedge i_clk) begin
        t_median got;
        if (i_rst_n) begin
            if (i_valid && o_ready)
                sb.note_word(i_action, {i_in_red, i_in_green, i_in_blue});
            if (o_valid && i_ready) begin
                got.red       = o_out_red;
                got.green     = o_out_green;
                got.blue      = o_out_blue;
                got.row_end   = o_row_end;
                got.frame_end = o_frame_end;
                sb.check_median(got);
            end
        end
    end

    initial begin
        #20ms;
        $display("[median3x3_rgb_filter] ERROR");
        $finish;
    end

    task automatic apb_write(logic idx, bit [31:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        sb.set_register(idx, value);
    endtask

    // offer one word and hold it until taken
    task automatic send_word(bit flush, t_ch r, t_ch g, t_ch b);
        if ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < send_idle_pct) @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_action   <= flush;
        i_in_red   <= r;
        i_in_green <= g;
        i_in_blue  <= b;
        do @(posedge i_clk); while (!o_ready);
        words_sent++;
    endtask

    task automatic go_idle();
        i_valid <= 1'b0;
        while (sb.medians_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic send_random_pixel();
        send_word(1'b0, t_ch'($urandom), t_ch'($urandom), t_ch'($urandom));
    endtask

    // one frame with random content, some noise, then the drain
    task automatic run_frame(int w, int h, int noise_pct);
        for (int i = 0; i < w * h; i++) begin
            if ($urandom_range(99) < noise_pct)
                send_word(1'b1, t_ch'($urandom), t_ch'($urandom), t_ch'($urandom));
            send_random_pixel();
        end
        for (int i = 0; i < w + 1 + $urandom_range(3); i++) begin
            if (i < w && $urandom_range(99) < noise_pct) send_random_pixel();
            send_word(1'b1, t_ch'($urandom), t_ch'($urandom), t_ch'($urandom));
        end
    endtask

    task automatic set_frame(int w, int h);
        apb_write(REG_WIDTH, w);
        apb_write(REG_HEIGHT, h);
    endtask

    initial begin
        int w;
        int h;
        int phase_base;
        sb = new();
        sb.reset_state();
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        i_valid = 1'b0;
        i_action = 1'b0;
        i_in_red = '0;
        i_in_green = '0;
        i_in_blue = '0;
        i_ready = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_cycles = 0;
        words_sent = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // small frame of extreme values, stray flushes and stray pixels
        set_frame(3, 3);
        send_word(1'b1, 8'hFF, 8'h00, 8'hFF);
        for (int i = 0; i < 9; i++)
            send_word(1'b0, (i % 2) ? 8'hFF : 8'h00, (i % 3) ? 8'h00 : 8'hFF,
                      (i < 4) ? 8'hFF : 8'h00);
        send_word(1'b1, 8'h00, 8'h00, 8'h00);
        send_word(1'b0, 8'hAA, 8'h55, 8'hAA);
        for (int i = 0; i < 4; i++) send_word(1'b1, 8'h00, 8'h00, 8'h00);
        send_word(1'b1, 8'h00, 8'h00, 8'h00);
        go_idle();
        // zero size acts as one, single pixel frame
        set_frame(0, 0);
        send_word(1'b0, 8'h12, 8'hFF, 8'h00);
        send_word(1'b1, 8'h00, 8'h00, 8'h00);
        send_word(1'b1, 8'h00, 8'h00, 8'h00);
        send_word(1'b1, 8'h00, 8'h00, 8'h00);
        go_idle();

        // widest setting is clamped to the line store depth: wrap into row one
        set_frame(2047, 65535);
        for (int i = 0; i < MAXW + 8; i++) send_random_pixel();
        go_idle();

        // tallest setting, abandoned after a few rows
        set_frame(4, 65535);
        for (int i = 0; i < 20; i++) send_random_pixel();
        go_idle();

        // long receiver hold-off while the sender keeps offering
        set_frame(8, 6);
        hold_cycles <= 400;
        run_frame(8, 6, 0);
        go_idle();

        // random frames over the idle and stall mixes
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 85; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 85; end
                default: begin send_idle_pct = 28; recv_stall_pct = 28; end
            endcase
            phase_base = words_sent;
            while (words_sent < phase_base + 130) begin
                w = ($urandom_range(9) == 0) ? $urandom_range(40, 16)
                                              : $urandom_range(12, 1);
                h = $urandom_range(6, 1);
                set_frame(w, h);
                run_frame(w, h, ($urandom_range(3) == 0) ? 5 : 0);
                if ($urandom_range(2) == 0) run_frame(w, h, 0);
                go_idle();
            end
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;
        go_idle();

        if (sb.errors == 0 && sb.medians_due.size() == 0) begin
            $display("[median3x3_rgb_filter] OK");
        end else begin
            if (sb.medians_due.size() != 0)
                $display("%0t: %0d results never arrived", $time,
                         sb.medians_due.size());
            $display("[median3x3_rgb_filter] ERROR");
        end
        $finish;
    end

endmodule
